// ===== hdl/gtc_pkg.sv =====
// Shared constants, codes and control types of the graph tree check block.
package gtc_pkg;

  // Graph capacity and derived widths
  localparam int MAX_VERTICES = 256;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int VCOUNT_W     = 9;
  localparam int FIELD_W      = 8;
  localparam int EDGE_W       = 9;
  // Count width: holds any vertex_count and any vertex index plus one
  localparam int CNT_W        = (VTX_W + 1 > VCOUNT_W) ? VTX_W + 1 : VCOUNT_W;

  localparam logic [EDGE_W-1:0] EDGE_SAT = '1;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_EVAL = 1'b1
  } gtc_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_UP,
    ST_FIND_GP
  } gtc_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // latch an edge request, update counters
    logic eval;       // produce result and clear the graph
    logic read_cur;   // read link of the current vertex
    logic step_up;    // read link of the parent
    logic halve;      // path halving: relink current to grandparent, move up
    logic save_root;  // first root found, start on second endpoint
    logic merge;      // second root found, join or flag a cycle
  } gtc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic edge_bad;   // incoming edge names a vertex out of range
    logic at_root;    // vertex just read links to itself
  } gtc_status_t;

endpackage

// ===== hdl/gtc_if.sv =====
// Valid/ready channel interfaces: input request, result, configuration write.
interface gtc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [gtc_pkg::FIELD_W-1:0] edge_from;
  logic [gtc_pkg::FIELD_W-1:0] edge_to;

  modport source (output valid, output opcode, output edge_from, output edge_to,
                  input ready);
  modport sink   (input valid, input opcode, input edge_from, input edge_to,
                  output ready);
endinterface

interface gtc_out_if;
  logic valid;
  logic ready;
  logic is_tree;
  logic bad_vertex;

  modport source (output valid, output is_tree, output bad_vertex, input ready);
  modport sink   (input valid, input is_tree, input bad_vertex, output ready);
endinterface

interface gtc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gtc_pkg::VCOUNT_W-1:0] vertex_count;

  modport source (output valid, output vertex_count, input ready);
  modport sink   (input valid, input vertex_count, output ready);
endinterface

// ===== hdl/gtc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/gtc_datapath.sv =====
// Datapath: union-find link memory, valid bits, counters, flags and result register.
module gtc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gtc_pkg::VCOUNT_W-1:0]  cfg_data_i,
  input  logic [gtc_pkg::FIELD_W-1:0]   edge_from_i,
  input  logic [gtc_pkg::FIELD_W-1:0]   edge_to_i,
  input  gtc_pkg::gtc_cmd_t             cmd_i,
  output gtc_pkg::gtc_status_t          status_o,
  output logic                          is_tree_o,
  output logic                          bad_vertex_o
);
  import gtc_pkg::*;

  logic [VCOUNT_W-1:0]     vcount_q;
  logic [CNT_W-1:0]        vcount_ext, n_act, from_ext, to_ext;
  logic [VTX_W-1:0]        a_addr, b_addr;
  logic [VTX_W-1:0]        b_q, cur_q, ra_q, maxv_q;
  logic [VTX_W-1:0]        rd_addr_q, rd_addr_d, link;
  logic                    rd_valid_q;
  logic [MAX_VERTICES-1:0] valid_q;
  logic [EDGE_W-1:0]       edges_q;
  logic                    cycle_q, range_q, is_tree_q, bad_q;
  logic                    re, we, tree;
  logic [VTX_W-1:0]        waddr, wdata, rdata, pair_max;
  logic                    edge_bad;

  // Active vertex count, capped at capacity
  assign vcount_ext = CNT_W'(vcount_q);
  assign n_act      = (vcount_ext > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                           : vcount_ext;

  // Range check on the incoming edge
  assign from_ext = CNT_W'(edge_from_i);
  assign to_ext   = CNT_W'(edge_to_i);
  assign edge_bad = (from_ext >= n_act) || (to_ext >= n_act);
  assign a_addr   = from_ext[VTX_W-1:0];
  assign b_addr   = to_ext[VTX_W-1:0];
  assign pair_max = (a_addr > b_addr) ? a_addr : b_addr;

  // Effective link of the last vertex read: never-written entries link to themselves
  assign link = rd_valid_q ? rdata : rd_addr_q;

  assign status_o.edge_bad = edge_bad;
  assign status_o.at_root  = (link == rd_addr_q);

  // Memory port selection
  always_comb begin
    re        = cmd_i.read_cur || cmd_i.step_up || cmd_i.halve;
    rd_addr_d = cmd_i.read_cur ? cur_q : link;
    we        = cmd_i.halve || (cmd_i.merge && (ra_q != cur_q));
    waddr     = cmd_i.halve ? cur_q : ra_q;
    wdata     = cmd_i.halve ? link : cur_q;
  end

  gtc_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rd_addr_d),
    .rdata_o (rdata)
  );

  // Tree decision: an acyclic, in-range edge set whose size is n_act less one spans all n_act vertices
  assign tree = (n_act != '0) && !range_q && !cycle_q &&
                (CNT_W'(edges_q) == n_act - CNT_W'(1)) &&
                (CNT_W'(maxv_q) < n_act);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_W'(1);
    end else if (cfg_we_i) begin
      vcount_q <= cfg_data_i;
    end
  end

  // Per-entry valid bits and read-side tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid_q <= valid_q[rd_addr_d];
      end
    end
  end

  // Graph statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edges_q <= '0;
      cycle_q <= 1'b0;
      range_q <= 1'b0;
      maxv_q  <= '0;
    end else if (cmd_i.eval) begin
      edges_q <= '0;
      cycle_q <= 1'b0;
      range_q <= 1'b0;
      maxv_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        if (edges_q != EDGE_SAT) begin
          edges_q <= edges_q + EDGE_W'(1);
        end
        if (edge_bad) begin
          range_q <= 1'b1;
        end else if (pair_max > maxv_q) begin
          maxv_q <= pair_max;
        end
      end
      if (cmd_i.merge && (ra_q == cur_q)) begin
        cycle_q <= 1'b1;
      end
    end
  end

  // Walk registers and result payload
  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_addr_q <= rd_addr_d;
    end
    if (cmd_i.load) begin
      cur_q <= a_addr;
      b_q   <= b_addr;
    end else if (cmd_i.save_root) begin
      ra_q  <= cur_q;
      cur_q <= b_q;
    end else if (cmd_i.halve) begin
      cur_q <= link;
    end
    if (cmd_i.eval) begin
      is_tree_q <= tree;
      bad_q     <= range_q;
    end
  end

  assign is_tree_o    = is_tree_q;
  assign bad_vertex_o = bad_q;

endmodule

// ===== hdl/gtc_controller.sv =====
// Controller: request handshake, root walk sequencing and result valid.
module gtc_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_opcode_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  gtc_pkg::gtc_status_t status_i,
  output gtc_pkg::gtc_cmd_t    cmd_o
);
  import gtc_pkg::*;

  gtc_state_e state_q, state_d;
  logic       side_q, side_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  // State, endpoint select and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    side_d     = side_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // edges go ahead while a result waits; evaluate needs a free slot
        in_ready_o = (in_opcode_i == OP_EDGE) || !out_valid_q || out_ready_i;
        accept     = in_valid_i && in_ready_o;
        if (accept) begin
          if (in_opcode_i == OP_EVAL) begin
            cmd_o.eval = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            if (!status_i.edge_bad) begin
              side_d  = 1'b0;
              state_d = ST_FIND_RD;
            end
          end
        end
      end
      ST_FIND_RD: begin
        cmd_o.read_cur = 1'b1;
        state_d        = ST_FIND_UP;
      end
      ST_FIND_UP: begin
        if (status_i.at_root) begin
          if (!side_q) begin
            cmd_o.save_root = 1'b1;
            side_d          = 1'b1;
            state_d         = ST_FIND_RD;
          end else begin
            cmd_o.merge = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          cmd_o.step_up = 1'b1;
          state_d       = ST_FIND_GP;
        end
      end
      ST_FIND_GP: begin
        cmd_o.halve = 1'b1;
        state_d     = ST_FIND_UP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.eval || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/graph_tree_check_core.sv =====
// Top level of the graph tree check: union-find edge loader with tree verdict.
// Evaluate gives its result in the cycle after acceptance; an out-of-range edge
// only updates the counters, an in-range edge walks to both roots and merges them,
// paced by the single read port of the link memory (two reads per halving step).
// Edges are taken while a result waits; evaluate waits for the result slot.
// Reset (async, active low) sets vertex_count to 1 and empties the graph at once.
module graph_tree_check_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  gtc_in_if.sink            in_i,
  gtc_out_if.source         out_o,
  gtc_cfg_if.sink           cfg_i
);
  import gtc_pkg::*;

  gtc_cmd_t    cmd;
  gtc_status_t status;

  assign cfg_i.ready = 1'b1;

  gtc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gtc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.vertex_count),
    .edge_from_i  (in_i.edge_from),
    .edge_to_i    (in_i.edge_to),
    .cmd_i        (cmd),
    .status_o     (status),
    .is_tree_o    (out_o.is_tree),
    .bad_vertex_o (out_o.bad_vertex)
  );

  // Evaluate request yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.opcode == OP_EVAL) |=> out_o.valid)
    else $error("evaluate request did not produce a result");

  // An in-range edge occupies the walk, so no request is taken next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.opcode == OP_EDGE) && !status.edge_bad
    |=> !in_i.ready)
    else $error("request taken during a root walk");

  // A range error always rules out a tree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.is_tree && out_o.bad_vertex))
    else $error("tree reported with a bad vertex");

  // Memory walk commands never coincide with a new request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.read_cur || cmd.step_up || cmd.halve || cmd.merge || cmd.save_root)
    |-> !(cmd.load || cmd.eval))
    else $error("walk command overlaps request command");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for graph_tree_check_core: random graphs checked against a union-find predictor.
`timescale 1ns / 1ps

module testbench;
  import gtc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 1200;   // longest edge walk, with margin
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned BIG_BUDGET    = 300;    // room needed for a large-count phase

  typedef struct packed {
    gtc_op_e              op;
    logic [FIELD_W-1:0]   v_a;
    logic [FIELD_W-1:0]   v_b;
  } edge_req_t;

  typedef struct packed {
    logic is_tree;
    logic bad_vertex;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gtc_in_if  in_if ();
  gtc_out_if out_if ();
  gtc_cfg_if cfg_if ();

  graph_tree_check_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #6 clk_i = ~clk_i;

  // Requests waiting to be driven, verdicts waiting to come back
  edge_req_t   pending_reqs[$];
  verdict_t    expected_verdicts[$];
  int unsigned fail_count;
  int unsigned total_items;
  bit          no_idle;
  logic [VCOUNT_W-1:0] stim_count;

  // Predictor state: union-find forest, counters, register copy
  logic [VTX_W-1:0]    link_mem [MAX_VERTICES];
  logic [EDGE_W-1:0]   edge_tally;
  bit                  cycle_seen;
  bit                  range_seen;
  logic [VCOUNT_W-1:0] count_reg;

  function automatic int unsigned active_n(input logic [VCOUNT_W-1:0] c);
    return (int'(c) > MAX_VERTICES) ? MAX_VERTICES : int'(c);
  endfunction

  function automatic void clear_forest();
    for (int i = 0; i < MAX_VERTICES; i++) link_mem[i] = VTX_W'(i);
    edge_tally = '0;
    cycle_seen = 1'b0;
    range_seen = 1'b0;
  endfunction

  // Root lookup with path halving
  function automatic int unsigned find_leader(input int unsigned v);
    int unsigned cur;
    int unsigned up;
    int unsigned hops;
    cur = v;
    hops = 0;
    while (int'(link_mem[cur]) != cur && hops < MAX_VERTICES) begin
      up = link_mem[cur];
      link_mem[cur] = link_mem[up];
      cur = link_mem[cur];
      hops++;
    end
    return cur;
  endfunction

  // Apply one accepted request; an evaluate queues its verdict
  function automatic void apply_request(input edge_req_t r);
    int unsigned n;
    int unsigned ra;
    int unsigned rb;
    int unsigned r0;
    bit          tree;
    verdict_t    vd;
    n = active_n(count_reg);
    if (r.op == OP_EDGE) begin
      if (edge_tally != EDGE_SAT) edge_tally++;
      if (r.v_a >= n || r.v_b >= n) begin
        range_seen = 1'b1;
      end else begin
        ra = find_leader(r.v_a);
        rb = find_leader(r.v_b);
        if (ra == rb) cycle_seen = 1'b1;
        else link_mem[ra] = VTX_W'(rb);
      end
    end else begin
      tree = (n >= 1) && !range_seen && !cycle_seen && (int'(edge_tally) == n - 1);
      if (tree) begin
        r0 = find_leader(0);
        for (int unsigned v = 1; v < n; v++) begin
          if (find_leader(v) != r0) begin
            tree = 1'b0;
            break;
          end
        end
      end
      vd.is_tree    = tree;
      vd.bad_vertex = range_seen;
      expected_verdicts.insert(expected_verdicts.size(), vd);
      clear_forest();
    end
  endfunction

  // Gap lengths: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Request driver
  int unsigned gap_left;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      gap_left = 0;
      in_if.valid     <= 1'b0;
      in_if.opcode    <= OP_EDGE;
      in_if.edge_from <= '0;
      in_if.edge_to   <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        apply_request('{gtc_op_e'(in_if.opcode), in_if.edge_from, in_if.edge_to});
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          edge_req_t nxt;
          nxt = pending_reqs.pop_front();
          in_if.valid     <= 1'b1;
          in_if.opcode    <= nxt.op;
          in_if.edge_from <= nxt.v_a;
          in_if.edge_to   <= nxt.v_b;
          gap_left = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  int unsigned stall_left;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left = 0;
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: is_tree=%0b bad_vertex=%0b",
                     out_if.is_tree, out_if.bad_vertex);
        end else begin
          verdict_t exp_v;
          exp_v = expected_verdicts.pop_front();
          if (out_if.is_tree !== exp_v.is_tree ||
              out_if.bad_vertex !== exp_v.bad_vertex) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected is_tree=%0b bad_vertex=%0b, ",
                        "got is_tree=%0b bad_vertex=%0b"},
                       exp_v.is_tree, exp_v.bad_vertex,
                       out_if.is_tree, out_if.bad_vertex);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic push_edge(input int unsigned a, input int unsigned b);
    @(negedge clk_i);
    pending_reqs.insert(pending_reqs.size(), '{OP_EDGE, FIELD_W'(a), FIELD_W'(b)});
    total_items++;
  endtask

  task automatic push_eval();
    @(negedge clk_i);
    pending_reqs.insert(pending_reqs.size(), '{OP_EVAL, FIELD_W'($urandom_range(0, 255)),
                                               FIELD_W'($urandom_range(0, 255))});
    total_items++;
  endtask

  // Block idle: nothing queued, nothing expected, edge walks finished
  task automatic settle();
    while (pending_reqs.size() != 0 || in_if.valid || expected_verdicts.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_count(input int unsigned value);
    settle();
    @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.vertex_count <= VCOUNT_W'(value);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    count_reg  = VCOUNT_W'(value);
    stim_count = VCOUNT_W'(value);
  endtask

  // Stimulus
  initial begin
    int unsigned p;
    int unsigned n;
    int unsigned kind;
    int unsigned graphs;
    int unsigned mid;
    int unsigned j;
    int unsigned perm [MAX_VERTICES];
    int unsigned tmp;
    bit          mid_switch;
    edge_req_t   edges[$];
    edge_req_t   e;

    rst_ni              = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.vertex_count = '0;
    fail_count  = 0;
    total_items = 0;
    no_idle     = 1'b0;
    count_reg   = VCOUNT_W'(1);
    stim_count  = VCOUNT_W'(1);
    clear_forest();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset count of one gives a single-vertex tree
    push_eval();
    // Count zero: every edge bad, empty graph is no tree
    set_count(0);
    push_edge(0, 0);
    push_eval();
    push_eval();
    // Path on three vertices
    set_count(3);
    push_edge(0, 1);
    push_edge(1, 2);
    push_eval();
    // Self-loop
    push_edge(1, 1);
    push_edge(0, 1);
    push_eval();
    // Duplicate edge
    set_count(2);
    push_edge(0, 1);
    push_edge(1, 0);
    push_eval();
    // Out-of-range endpoints on either side, field extremes
    set_count(4);
    push_edge(255, 3);
    push_edge(0, 255);
    push_edge(1, 2);
    push_eval();
    // Count raised while loading
    set_count(2);
    push_edge(0, 1);
    set_count(3);
    push_edge(2, 1);
    push_eval();
    // Count lowered while loading
    push_edge(0, 1);
    push_edge(1, 2);
    set_count(2);
    push_eval();
    // Count above capacity
    set_count(300);
    push_eval();

    // Random phases: mostly random trees, some broken, some noise
    total_items = 0;
    while (total_items < RANDOM_ITEMS) begin
      p = $urandom_range(0, 99);
      if (p < 8) set_count($urandom_range(0, 1));
      else if (p < 80) set_count($urandom_range(2, 12));
      else if (p < 90) set_count($urandom_range(13, 64));
      else if (total_items + BIG_BUDGET > RANDOM_ITEMS) set_count($urandom_range(2, 12));
      else if (p < 95) set_count($urandom_range(200, 256));
      else set_count($urandom_range(257, 511));
      no_idle = ($urandom_range(0, 4) == 0);
      graphs = (active_n(stim_count) > 12) ? 1 : $urandom_range(1, 4);
      for (int unsigned g = 0; g < graphs; g++) begin
        n = active_n(stim_count);
        // Random labeling and random attachment give a random spanning tree
        for (int unsigned i = 0; i < n; i++) perm[i] = i;
        for (int unsigned i = n; i > 1; i--) begin
          j = $urandom_range(0, i - 1);
          tmp = perm[i-1];
          perm[i-1] = perm[j];
          perm[j] = tmp;
        end
        edges.delete();
        for (int unsigned v = 1; v < n; v++)
          edges.insert(edges.size(), '{OP_EDGE, FIELD_W'(perm[v]),
                                       FIELD_W'(perm[$urandom_range(0, v - 1)])});
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          // well-formed tree
        end else if (kind < 55) begin
          if (edges.size() != 0) edges.delete($urandom_range(0, edges.size() - 1));
        end else if (kind < 63) begin
          if (edges.size() != 0) begin
            e = edges[$urandom_range(0, edges.size() - 1)];
            edges.insert(edges.size(), e);
          end
        end else if (kind < 71 || (kind < 79 && n >= MAX_VERTICES)) begin
          tmp = (n == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
          edges.insert(edges.size(), '{OP_EDGE, FIELD_W'(tmp), FIELD_W'(tmp)});
        end else if (kind < 79) begin
          edges.insert(edges.size(), '{OP_EDGE, FIELD_W'($urandom_range(n, 255)),
                                       FIELD_W'($urandom_range(0, 255))});
        end else if (kind < 87) begin
          if (n != 0)
            edges.insert(edges.size(), '{OP_EDGE, FIELD_W'($urandom_range(0, n - 1)),
                                         FIELD_W'($urandom_range(0, n - 1))});
        end else begin
          edges.delete();
          repeat ($urandom_range(0, 12))
            edges.insert(edges.size(), '{OP_EDGE, FIELD_W'($urandom_range(0, 255)),
                                         FIELD_W'($urandom_range(0, 255))});
        end
        // Shuffle edge order
        for (int unsigned i = edges.size(); i > 1; i--) begin
          j = $urandom_range(0, i - 1);
          e = edges[i-1];
          edges[i-1] = edges[j];
          edges[j] = e;
        end
        mid = edges.size() / 2;
        mid_switch = ($urandom_range(0, 11) == 0);
        for (int unsigned i = 0; i < edges.size(); i++) begin
          if (mid_switch && i == mid) set_count($urandom_range(1, 12));
          if ($urandom_range(0, 1) != 0) push_edge(edges[i].v_b, edges[i].v_a);
          else push_edge(edges[i].v_a, edges[i].v_b);
        end
        push_eval();
      end
    end

    settle();
    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #120_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
